// ===== sv/i2c_bit_level_master_assert.svh =====
// Assertion macros used by the I2C line sequencer back module, i2cbm_back.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CBM_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CBM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2cbm_pkg.sv =====
`default_nettype none

package i2cbm_pkg;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_SEND_ACK = 3'd5;
    localparam logic [2:0] CMD_RECV_ACK = 3'd6;
    localparam logic [2:0] CMD_PROBE    = 3'd7;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
    localparam int          IDX_W             = 6;
    localparam logic [5:0]  IDX_LAST_PROBE    = 6'd35;

    typedef enum logic [3:0] {
        ACT_SCL_LO,
        ACT_SCL_HI,
        ACT_SDA_LO,
        ACT_SDA_HI,
        ACT_SDA_BIT,
        ACT_SDA_ACK,
        ACT_SAMPLE_BIT,
        ACT_SAMPLE_ACK,
        ACT_END
    } act_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] shift_init;
        logic [1:0] sub_init;
        logic       ack_bit;
        logic       sda_in;
    } item_t;

    function automatic act_t start_act(input logic [1:0] k);
        act_t a;
        case (k)
            2'd0:    a = ACT_SDA_HI;
            2'd1:    a = ACT_SCL_HI;
            2'd2:    a = ACT_SDA_LO;
            default: a = ACT_SCL_LO;
        endcase
        return a;
    endfunction

    function automatic act_t stop_act(input logic [1:0] k);
        act_t a;
        case (k)
            2'd0:    a = ACT_SCL_LO;
            2'd1:    a = ACT_SDA_LO;
            2'd2:    a = ACT_SCL_HI;
            default: a = ACT_SDA_HI;
        endcase
        return a;
    endfunction

    function automatic act_t recv_act(input logic [1:0] k);
        act_t a;
        case (k)
            2'd0:    a = ACT_SDA_HI;
            2'd1:    a = ACT_SCL_HI;
            2'd2:    a = ACT_SAMPLE_ACK;
            default: a = ACT_SCL_LO;
        endcase
        return a;
    endfunction

    function automatic act_t send_act(input logic [1:0] k);
        act_t a;
        case (k)
            2'd0:    a = ACT_SDA_ACK;
            2'd1:    a = ACT_SCL_HI;
            2'd2:    a = ACT_SCL_LO;
            default: a = ACT_END;
        endcase
        return a;
    endfunction

    function automatic act_t byte_act(input logic [1:0] sub);
        act_t a;
        case (sub)
            2'd0:    a = ACT_SDA_BIT;
            2'd1:    a = ACT_SCL_HI;
            default: a = ACT_SCL_LO;
        endcase
        return a;
    endfunction

    function automatic act_t read_act(input logic [1:0] sub);
        act_t a;
        case (sub)
            2'd0:    a = ACT_SCL_HI;
            2'd1:    a = ACT_SAMPLE_BIT;
            default: a = ACT_SCL_LO;
        endcase
        return a;
    endfunction

    // The sub argument is the position within a three-phase bit slot, kept by a counter.
    function automatic act_t phase_action(input logic [2:0] c, input logic [IDX_W-1:0] i,
                                          input logic [1:0] sub);
        act_t a;
        a = ACT_END;
        case (c)
            CMD_START:    a = (i < 6'd4) ? start_act(i[1:0]) : ACT_END;
            CMD_STOP:     a = (i < 6'd4) ? stop_act(i[1:0]) : ACT_END;
            CMD_WRITE:    a = (i < 6'd24) ? byte_act(sub) : ACT_END;
            CMD_READ:
            begin
                if (i == 6'd0) a = ACT_SDA_HI;
                else if (i > 6'd24) a = ACT_END;
                else a = read_act(sub);
            end
            CMD_SEND_ACK: a = (i < 6'd3) ? send_act(i[1:0]) : ACT_END;
            CMD_RECV_ACK: a = (i < 6'd4) ? recv_act(i[1:0]) : ACT_END;
            CMD_PROBE:
            begin
                if (i < 6'd4) a = start_act(i[1:0]);
                else if (i < 6'd28) a = byte_act(sub);
                else if (i < 6'd32) a = recv_act(i[1:0]);
                else if (i < 6'd36) a = stop_act(i[1:0]);
                else a = ACT_END;
            end
            default:      a = ACT_END;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== sv/i2c_bit_level_master.sv =====
// I2C master line sequencer. Each request is one timing tick carrying an optional command
// and the sampled SDA level, and each request yields exactly one result with the SCL and
// SDA drive levels, busy and done flags, the last read byte and the last sampled ack. One
// request is taken and one result is produced every clock cycle in steady state; each
// request passes through a registered two-entry request queue and then a registered
// two-entry result queue, and the sequencer stalls only when the result queue is full or
// no request is waiting.
// The phase length register is written through cfg_we and cfg_wdata; the user must write
// it only while no request is in flight, which the block itself does not enforce.
`default_nettype none

module i2c_bit_level_master (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  data_byte,
    input  wire logic        ack_bit,
    input  wire logic        sda_in,
    output logic             empty,
    input  wire logic        pop,
    output logic             scl_out,
    output logic             sda_out,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       read_byte,
    output logic             ack_seen
);

    i2cbm_pkg::item_t item;
    logic             item_valid;
    logic             item_take;

    i2cbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .ack_bit    (ack_bit),
        .sda_in     (sda_in),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    i2cbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .scl_out    (scl_out),
        .sda_out    (sda_out),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .read_byte  (read_byte),
        .ack_seen   (ack_seen)
    );

endmodule

`default_nettype wire

// ===== sv/i2cbm_front.sv =====
`default_nettype none

module i2cbm_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [2:0]          cmd,
    input  wire logic [7:0]          data_byte,
    input  wire logic                ack_bit,
    input  wire logic                sda_in,
    output i2cbm_pkg::item_t         item,
    output logic                     item_valid,
    input  wire logic                item_take
);

    i2cbm_pkg::item_t q_reg [2];
    i2cbm_pkg::item_t item_new;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // A read starts from a cleared shift register; read and probe start their bit slot
    // counter so that it reads zero on the first phase of the byte.
    always_comb
    begin
        item_new.cmd        = cmd;
        item_new.shift_init = (cmd == i2cbm_pkg::CMD_READ) ? 8'd0 : data_byte;
        item_new.sub_init   = ((cmd == i2cbm_pkg::CMD_READ) || (cmd == i2cbm_pkg::CMD_PROBE))
                              ? 2'd2 : 2'd0;
        item_new.ack_bit    = ack_bit;
        item_new.sda_in     = sda_in;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop) rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) q_reg[wr_ptr_reg] <= item_new;
    end

endmodule

`default_nettype wire

// ===== sv/i2cbm_back.sv =====
`default_nettype none

module i2cbm_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [15:0]         cfg_wdata,
    input  wire i2cbm_pkg::item_t    item,
    input  wire logic                item_valid,
    output logic                     item_take,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     scl_out,
    output logic                     sda_out,
    output logic                     busy_res,
    output logic                     done_res,
    output logic [7:0]               read_byte,
    output logic                     ack_seen
);

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } result_t;

    logic [15:0]                  ptick_reg;
    logic [2:0]                   active_reg, active_next;
    logic [i2cbm_pkg::IDX_W-1:0]  idx_reg, idx_next, idx_inc;
    logic [1:0]                   sub_reg, sub_next, sub_inc;
    logic [15:0]                  timer_reg, timer_next, reload;
    logic [7:0]                   shift_reg, shift_next, shift_base;
    logic                         scl_reg, scl_next;
    logic                         sda_reg, sda_next;
    logic                         ack_reg, ack_next;
    logic [7:0]                   rx_reg, rx_next;
    logic                         held_reg, held_next, held_base;
    logic                         done;
    logic                         apply_en;
    i2cbm_pkg::act_t              act;

    result_t                      oq_reg [2];
    result_t                      res;
    result_t                      head;
    logic                         ow_ptr_reg;
    logic                         or_ptr_reg;
    logic [1:0]                   out_cnt_reg;
    logic [1:0]                   out_cnt_next;
    logic                         proc;
    logic                         out_pop;

    assign proc      = item_valid && (out_cnt_reg != 2'd2);
    assign item_take = proc;
    assign out_pop   = pop && !empty;
    assign empty     = (out_cnt_reg == 2'd0);

    assign idx_inc = idx_reg + 6'd1;
    assign sub_inc = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
    assign reload  = (ptick_reg == 16'd0) ? 16'd0 : ptick_reg - 16'd1;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        sub_next    = sub_reg;
        timer_next  = timer_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        ack_next    = ack_reg;
        rx_next     = rx_reg;
        held_next   = held_reg;
        shift_base  = shift_reg;
        held_base   = held_reg;
        done        = 1'b0;
        apply_en    = 1'b0;
        act         = i2cbm_pkg::ACT_END;

        if (active_reg == i2cbm_pkg::CMD_NONE)
        begin
            if (item.cmd != i2cbm_pkg::CMD_NONE)
            begin
                active_next = item.cmd;
                idx_next    = '0;
                sub_next    = item.sub_init;
                held_next   = item.ack_bit;
                held_base   = item.ack_bit;
                shift_base  = item.shift_init;
                act         = i2cbm_pkg::phase_action(item.cmd, '0, item.sub_init);
                apply_en    = 1'b1;
            end
        end
        else if (timer_reg != 16'd0)
        begin
            timer_next = timer_reg - 16'd1;
        end
        else
        begin
            act = i2cbm_pkg::phase_action(active_reg, idx_inc, sub_inc);
            if (act == i2cbm_pkg::ACT_END)
            begin
                if (active_reg == i2cbm_pkg::CMD_READ) rx_next = shift_reg;
                active_next = i2cbm_pkg::CMD_NONE;
                idx_next    = '0;
                timer_next  = 16'd0;
                done        = 1'b1;
            end
            else
            begin
                idx_next = idx_inc;
                sub_next = sub_inc;
                apply_en = 1'b1;
            end
        end

        shift_next = shift_base;
        if (apply_en)
        begin
            timer_next = reload;
            case (act)
                i2cbm_pkg::ACT_SCL_LO:     scl_next = 1'b0;
                i2cbm_pkg::ACT_SCL_HI:     scl_next = 1'b1;
                i2cbm_pkg::ACT_SDA_LO:     sda_next = 1'b0;
                i2cbm_pkg::ACT_SDA_HI:     sda_next = 1'b1;
                i2cbm_pkg::ACT_SDA_BIT:
                begin
                    // Bits leave from the top of the shift register, MSB first.
                    sda_next   = shift_base[7];
                    shift_next = {shift_base[6:0], 1'b0};
                end
                i2cbm_pkg::ACT_SDA_ACK:    sda_next = held_base;
                i2cbm_pkg::ACT_SAMPLE_BIT: shift_next = {shift_base[6:0], item.sda_in};
                i2cbm_pkg::ACT_SAMPLE_ACK: ack_next = item.sda_in;
                default:                   ;
            endcase
        end

        res.scl  = scl_next;
        res.sda  = sda_next;
        res.busy = (active_next != i2cbm_pkg::CMD_NONE);
        res.done = done;
        res.rx   = rx_next;
        res.ack  = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptick_reg  <= i2cbm_pkg::PHASE_TICKS_RESET;
            active_reg <= i2cbm_pkg::CMD_NONE;
            idx_reg    <= '0;
            sub_reg    <= 2'd0;
            timer_reg  <= 16'd0;
            shift_reg  <= 8'd0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            ack_reg    <= 1'b1;
            rx_reg     <= 8'd0;
            held_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we) ptick_reg <= cfg_wdata;
            if (proc)
            begin
                active_reg <= active_next;
                idx_reg    <= idx_next;
                sub_reg    <= sub_next;
                timer_reg  <= timer_next;
                shift_reg  <= shift_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                ack_reg    <= ack_next;
                rx_reg     <= rx_next;
                held_reg   <= held_next;
            end
        end
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (proc && !out_pop) out_cnt_next = out_cnt_reg + 2'd1;
        else if (out_pop && !proc) out_cnt_next = out_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ow_ptr_reg  <= 1'b0;
            or_ptr_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            if (proc) ow_ptr_reg <= !ow_ptr_reg;
            if (out_pop) or_ptr_reg <= !or_ptr_reg;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc) oq_reg[ow_ptr_reg] <= res;
    end

    assign head      = oq_reg[or_ptr_reg];
    assign scl_out   = head.scl;
    assign sda_out   = head.sda;
    assign busy_res  = head.busy;
    assign done_res  = head.done;
    assign read_byte = head.rx;
    assign ack_seen  = head.ack;

    `include "i2c_bit_level_master_assert.svh"

    `I2CBM_ASSERT_SAME(a_idle_clean, active_reg == i2cbm_pkg::CMD_NONE, (idx_reg == '0) && (timer_reg == 16'd0), "idle sequencer holds a phase index or timer")
    `I2CBM_ASSERT_SAME(a_idx_bound, 1'b1, idx_reg <= i2cbm_pkg::IDX_LAST_PROBE, "phase index past the longest sequence")
    `I2CBM_ASSERT_SAME(a_sub_bound, 1'b1, sub_reg != 2'd3, "bit slot counter out of range")
    `I2CBM_ASSERT_NEXT(a_done_idle, proc && done, active_reg == i2cbm_pkg::CMD_NONE, "sequencer still active after finishing")
    `I2CBM_ASSERT_SAME(a_done_busy, proc && done, !res.busy, "finish tick reported as busy")

endmodule

`default_nettype wire

// ===== bench/tb_i2c_bit_level_master.sv =====
`default_nettype none

module tb_i2c_bit_level_master;
    import i2cbm_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int ITEM_GOAL = 740;

    typedef struct packed {
        bit [2:0] cmd;
        bit [7:0] data;
        bit       ackb;
        bit       sda;
    } tick_t;

    typedef struct packed {
        bit       scl;
        bit       sda;
        bit       busy;
        bit       done;
        bit [7:0] rbyte;
        bit       ack;
    } line_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  cmd = CMD_NONE;
    logic [7:0]  data_byte = 8'd0;
    logic        ack_bit = 1'b0;
    logic        sda_in = 1'b1;
    logic        empty;
    logic        pop = 1'b0;
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_byte;
    logic        ack_seen;

    i2c_bit_level_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .data_byte (data_byte),
        .ack_bit   (ack_bit),
        .sda_in    (sda_in),
        .empty     (empty),
        .pop       (pop),
        .scl_out   (scl_out),
        .sda_out   (sda_out),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .read_byte (read_byte),
        .ack_seen  (ack_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tick_t        pending_ticks[$];
    line_result_t expected_lines[$];

    bit [15:0] cur_ticks;
    bit [15:0] m_timer;
    bit [5:0]  m_index;
    bit [2:0]  m_cmd;
    bit [7:0]  m_shift;
    bit        m_scl;
    bit        m_sda;
    bit        m_ack;
    bit        m_held_ack;
    bit [7:0]  m_rx;

    bit calm = 1'b0;
    bit push_taken = 1'b0;
    int push_gap = 0;
    int pop_gap = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int results_checked = 0;
    int commands_queued = 0;
    int queued_ticks = 0;

    function automatic act_t framing_step(input bit [2:0] c, input bit [1:0] k);
        act_t a;
        case (c)
            CMD_START:
                case (k)
                    2'd0:    a = ACT_SDA_HI;
                    2'd1:    a = ACT_SCL_HI;
                    2'd2:    a = ACT_SDA_LO;
                    default: a = ACT_SCL_LO;
                endcase
            CMD_STOP:
                case (k)
                    2'd0:    a = ACT_SCL_LO;
                    2'd1:    a = ACT_SDA_LO;
                    2'd2:    a = ACT_SCL_HI;
                    default: a = ACT_SDA_HI;
                endcase
            CMD_RECV_ACK:
                case (k)
                    2'd0:    a = ACT_SDA_HI;
                    2'd1:    a = ACT_SCL_HI;
                    2'd2:    a = ACT_SAMPLE_ACK;
                    default: a = ACT_SCL_LO;
                endcase
            default:
                case (k)
                    2'd0:    a = ACT_SDA_ACK;
                    2'd1:    a = ACT_SCL_HI;
                    2'd2:    a = ACT_SCL_LO;
                    default: a = ACT_END;
                endcase
        endcase
        return a;
    endfunction

    function automatic act_t bit_slot_step(input int j);
        act_t a;
        case (j % 3)
            0:       a = ACT_SDA_BIT;
            1:       a = ACT_SCL_HI;
            default: a = ACT_SCL_LO;
        endcase
        return a;
    endfunction

    function automatic act_t line_action(input bit [2:0] c, input bit [5:0] i);
        act_t a;
        int   n;
        n = int'(i);
        a = ACT_END;
        case (c)
            CMD_START, CMD_STOP, CMD_RECV_ACK:
                if (n < 4) a = framing_step(c, i[1:0]);
            CMD_SEND_ACK:
                if (n < 3) a = framing_step(c, i[1:0]);
            CMD_WRITE:
                if (n < 24) a = bit_slot_step(n);
            CMD_READ:
            begin
                if (n == 0) a = ACT_SDA_HI;
                else if (n <= 24)
                begin
                    case ((n - 1) % 3)
                        0:       a = ACT_SCL_HI;
                        1:       a = ACT_SAMPLE_BIT;
                        default: a = ACT_SCL_LO;
                    endcase
                end
            end
            CMD_PROBE:
            begin
                if (n < 4) a = framing_step(CMD_START, i[1:0]);
                else if (n < 28) a = bit_slot_step(n - 4);
                else if (n < 32) a = framing_step(CMD_RECV_ACK, i[1:0]);
                else if (n < 36) a = framing_step(CMD_STOP, i[1:0]);
            end
            default: a = ACT_END;
        endcase
        return a;
    endfunction

    function automatic int phase_count(input bit [2:0] c);
        int n;
        case (c)
            CMD_WRITE:    n = 24;
            CMD_READ:     n = 25;
            CMD_SEND_ACK: n = 3;
            CMD_PROBE:    n = 36;
            default:      n = 4;
        endcase
        return n;
    endfunction

    task reset_model();
        cur_ticks = PHASE_TICKS_RESET;
        m_timer = 16'd0;
        m_index = 6'd0;
        m_cmd = CMD_NONE;
        m_shift = 8'd0;
        m_scl = 1'b1;
        m_sda = 1'b1;
        m_ack = 1'b1;
        m_held_ack = 1'b0;
        m_rx = 8'd0;
    endtask

    task enter_phase(input bit sda);
        int       bp;
        bit [2:0] bsel;
        case (line_action(m_cmd, m_index))
            ACT_SCL_LO: m_scl = 1'b0;
            ACT_SCL_HI: m_scl = 1'b1;
            ACT_SDA_LO: m_sda = 1'b0;
            ACT_SDA_HI: m_sda = 1'b1;
            ACT_SDA_BIT:
            begin
                bp = (m_cmd == CMD_PROBE) ? (int'(m_index) - 4) / 3 : int'(m_index) / 3;
                bsel = 3'd7 - bp[2:0];
                m_sda = m_shift[bsel];
            end
            ACT_SDA_ACK:    m_sda = m_held_ack;
            ACT_SAMPLE_BIT: m_shift = {m_shift[6:0], sda};
            ACT_SAMPLE_ACK: m_ack = sda;
            default: ;
        endcase
        m_timer = (cur_ticks == 16'd0) ? 16'd0 : cur_ticks - 16'd1;
    endtask

    task predict_tick(input tick_t t, output line_result_t r);
        bit done;
        done = 1'b0;
        if (m_cmd == CMD_NONE)
        begin
            if (t.cmd != CMD_NONE)
            begin
                m_cmd = t.cmd;
                m_index = 6'd0;
                m_held_ack = t.ackb;
                m_shift = (t.cmd == CMD_READ) ? 8'd0 : t.data;
                enter_phase(t.sda);
            end
        end
        else if (m_timer > 16'd0)
        begin
            m_timer = m_timer - 16'd1;
        end
        else
        begin
            m_index = m_index + 6'd1;
            if (line_action(m_cmd, m_index) == ACT_END)
            begin
                if (m_cmd == CMD_READ) m_rx = m_shift;
                m_cmd = CMD_NONE;
                m_index = 6'd0;
                m_timer = 16'd0;
                done = 1'b1;
            end
            else
            begin
                enter_phase(t.sda);
            end
        end
        r.scl = m_scl;
        r.sda = m_sda;
        r.busy = (m_cmd != CMD_NONE);
        r.done = done;
        r.rbyte = m_rx;
        r.ack = m_ack;
    endtask

    always @(negedge clk)
    begin
        if (push_taken)
        begin
            void'(pending_ticks.pop_front());
            push_taken = 1'b0;
        end
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (push_gap > 0)
        begin
            push_gap--;
            push <= 1'b0;
        end
        else if (!calm && $urandom_range(11) == 0)
        begin
            push_gap = $urandom_range(18, 0);
            push <= 1'b0;
        end
        else if (pending_ticks.size() > 0)
        begin
            push <= 1'b1;
            cmd <= pending_ticks[0].cmd;
            data_byte <= pending_ticks[0].data;
            ack_bit <= pending_ticks[0].ackb;
            sda_in <= pending_ticks[0].sda;
        end
        else
        begin
            push <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (pop_gap > 0)
        begin
            pop_gap--;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(11) == 0)
        begin
            pop_gap = $urandom_range(18, 0);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        tick_t        t;
        line_result_t r;
        line_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            if (rst_n && push && !full)
            begin
                t.cmd = cmd;
                t.data = data_byte;
                t.ackb = ack_bit;
                t.sda = sda_in;
                predict_tick(t, r);
                expected_lines.push_back(r);
                push_taken = 1'b1;
            end
            if (rst_n && pop && !empty)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("result arrived with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    results_checked++;
                    if (scl_out !== want.scl)
                    begin
                        $error("scl_out: expected %0d, got %0d", want.scl, scl_out);
                        mismatches++;
                    end
                    if (sda_out !== want.sda)
                    begin
                        $error("sda_out: expected %0d, got %0d", want.sda, sda_out);
                        mismatches++;
                    end
                    if (busy_res !== want.busy)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy, busy_res);
                        mismatches++;
                    end
                    if (done_res !== want.done)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done, done_res);
                        mismatches++;
                    end
                    if (read_byte !== want.rbyte)
                    begin
                        $error("read_byte: expected 0x%02h, got 0x%02h", want.rbyte, read_byte);
                        mismatches++;
                    end
                    if (ack_seen !== want.ack)
                    begin
                        $error("ack_seen: expected %0d, got %0d", want.ack, ack_seen);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic bit pick_sda(input int sda_fix);
        return (sda_fix < 0) ? bit'($urandom_range(1, 0)) : bit'(sda_fix);
    endfunction

    task queue_idle(input int n);
        tick_t t;
        for (int k = 0; k < n; k++)
        begin
            t.cmd = CMD_NONE;
            t.data = 8'($urandom_range(255, 0));
            t.ackb = 1'($urandom_range(1, 0));
            t.sda = 1'($urandom_range(1, 0));
            pending_ticks.push_back(t);
            queued_ticks++;
        end
    endtask

    // The command tick is followed by enough ticks to reach its finish tick. Commands
    // sprinkled over those ticks arrive while the sequencer is busy and must be ignored.
    task queue_command(input bit [2:0] c, input bit [7:0] d, input bit a, input int noise,
                       input bit poke_finish, input int sda_fix);
        tick_t t;
        int    n;
        n = phase_count(c) * ((cur_ticks == 16'd0) ? 1 : int'(cur_ticks));
        t.cmd = c;
        t.data = d;
        t.ackb = a;
        t.sda = pick_sda(sda_fix);
        pending_ticks.push_back(t);
        for (int k = 1; k <= n; k++)
        begin
            t.cmd = ($urandom_range(99, 0) < noise) ? 3'($urandom_range(7, 1)) : CMD_NONE;
            if (k == n && poke_finish) t.cmd = 3'($urandom_range(7, 1));
            t.data = 8'($urandom_range(255, 0));
            t.ackb = 1'($urandom_range(1, 0));
            t.sda = pick_sda(sda_fix);
            pending_ticks.push_back(t);
        end
        queued_ticks += n + 1;
        commands_queued++;
    endtask

    task wait_drained();
        while (pending_ticks.size() > 0 || expected_lines.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task set_ticks(input bit [15:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        cur_ticks = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        int first_random;
        int choice;
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_idle(3);
        queue_command(CMD_SEND_ACK, 8'h3C, 1'b1, 0, 1'b0, -1);
        wait_drained();

        set_ticks(16'd1);
        queue_command(CMD_START, 8'h00, 1'b0, 0, 1'b0, -1);
        queue_command(CMD_WRITE, 8'hA5, 1'b0, 0, 1'b0, -1);
        queue_command(CMD_RECV_ACK, 8'h00, 1'b0, 0, 1'b0, 0);
        queue_command(CMD_READ, 8'hFF, 1'b1, 0, 1'b0, 1);
        queue_command(CMD_SEND_ACK, 8'h00, 1'b0, 0, 1'b0, -1);
        queue_command(CMD_READ, 8'h00, 1'b0, 0, 1'b1, 0);
        queue_idle(1);
        queue_command(CMD_SEND_ACK, 8'hFF, 1'b1, 50, 1'b0, -1);
        queue_command(CMD_RECV_ACK, 8'hFF, 1'b1, 0, 1'b0, 1);
        queue_command(CMD_STOP, 8'h00, 1'b0, 0, 1'b1, -1);
        queue_idle(2);
        queue_command(CMD_PROBE, 8'hFF, 1'b0, 20, 1'b0, 0);
        queue_command(CMD_PROBE, 8'h00, 1'b1, 0, 1'b0, 1);
        queue_command(CMD_WRITE, 8'hFF, 1'b1, 0, 1'b0, -1);
        queue_command(CMD_WRITE, 8'h00, 1'b0, 0, 1'b0, -1);
        wait_drained();

        set_ticks(16'd0);
        queue_command(CMD_START, 8'h5A, 1'b0, 0, 1'b0, -1);
        queue_command(CMD_READ, 8'h00, 1'b0, 0, 1'b0, -1);
        queue_command(CMD_PROBE, 8'hC3, 1'b1, 0, 1'b1, -1);
        wait_drained();

        first_random = 1;
        while (queued_ticks < ITEM_GOAL)
        begin
            choice = $urandom_range(5, 0);
            if (choice < 3) set_ticks(16'd1);
            else if (choice == 3) set_ticks(16'd2);
            else if (choice == 4) set_ticks(16'd3);
            else set_ticks(16'($urandom_range(6, 4)));
            calm = ($urandom_range(3, 0) == 0);
            if (first_random)
            begin
                @(posedge clk);
                hold_req++;
                first_random = 0;
            end
            for (int k = $urandom_range(12, 5); k > 0 && queued_ticks < ITEM_GOAL; k--)
            begin
                queue_idle($urandom_range(3, 0));
                queue_command(3'($urandom_range(7, 1)), 8'($urandom_range(255, 0)),
                              1'($urandom_range(1, 0)), 10, ($urandom_range(7, 0) == 0),
                              ($urandom_range(9, 0) == 0) ? int'($urandom_range(1, 0)) : -1);
            end
            wait_drained();
        end

        calm = 1'b1;
        set_ticks(16'd20);
        queue_command(CMD_SEND_ACK, 8'($urandom_range(255, 0)), 1'b0, 1, 1'b1, -1);
        queue_idle(4);
        wait_drained();

        $display("Ran %0d commands of all seven kinds over %0d checked line ticks,",
                 commands_queued, results_checked);
        $display("phase lengths 0 to 100, with busy commands, idle gaps and result stalls.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/i2cbm_pkg.sv
sv/i2cbm_front.sv
sv/i2cbm_back.sv
sv/i2c_bit_level_master.sv
bench/tb_i2c_bit_level_master.sv
